>>> hdl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// shared types and constants of the spi register frame engine
// ----------------------------------------------------------------------------
package sfe_pkg;

  // item kinds on the input stream
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_WORD    = 2'd1,
    CMD_RX_BYTE = 2'd2
  } cmd_e;

  // frame opcodes, bit 0 set means a write opcode
  typedef enum logic [1:0] {
    OPC_READ      = 2'd0,
    OPC_WRITE     = 2'd1,
    OPC_SEQ_READ  = 2'd2,
    OPC_SEQ_WRITE = 2'd3
  } opcode_e;

  localparam int unsigned OpcWriteBit = 0;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_ZERO_COUNT = 2'd1,
    STATUS_STRAY      = 2'd2
  } status_e;

  // jobs handed from the front to the back
  typedef enum logic [1:0] {
    JOB_HEADER,
    JOB_WORD,
    JOB_RX_WORD,
    JOB_ERROR
  } job_kind_e;

  localparam int unsigned JobDataW   = 56;
  localparam int unsigned IdxW       = 19;
  localparam int unsigned ShiftW     = 4;
  localparam int unsigned HdrLastIdx = 6;
  localparam int unsigned WordLastIdx = 3;
  localparam int unsigned PadLastIdx  = 4;
  localparam int unsigned FrameOverhead = 8;
  localparam int unsigned FirstDataRx   = 9;

  // input and output stream payload widths
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 4;

  localparam int unsigned QueueDepthDefault = 4;

  typedef struct packed {
    job_kind_e             kind;
    logic [JobDataW-1:0]   data;   // header msb first, tx word top, rx word low
    logic                  pad;    // word job also sends the pad byte
    status_e               status;
  } job_t;

  // control between queue and back end
  typedef struct packed {
    logic not_empty;
    job_t head;
  } queue_head_t;

endpackage

>>> hdl/spi_register_frame_engine.sv
// ----------------------------------------------------------------------------
// spi_register_frame_engine
// master side byte engine for full duplex spi register access frames
// ----------------------------------------------------------------------------
// One input transfer is taken in every cycle while the job queue has room; the
// front end classifies it, updates the frame state and deskews received data
// in that same cycle. The back end then sends one result transfer per cycle
// while the output is ready, so a start item gives one transfer per header
// byte, a payload word one per word byte (plus one for the pad byte on the last
// word of a frame), a received byte at most one and an error exactly one.
// Sustained rate is set by the single output port: one result per cycle while
// the output is ready. The queue (QUEUE_DEPTH jobs) lets the input side keep
// going while results still wait on the output. read_shift is written over the
// cfg channel, always ready, and must only change while the engine is idle.
module spi_register_frame_engine #(
  parameter int unsigned QUEUE_DEPTH = sfe_pkg::QueueDepthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel, read_shift
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sfe_pkg::ShiftW-1:0]       cfg_data_i,
  // input item stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // opcode[1:0], address[33:2], word_count[49:34], tx_word[81:50],
  // rx_byte[89:82], zero fill [95:90]
  input  logic [sfe_pkg::InDataW-1:0]      s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]                       s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tx_out[7:0], rx_word[39:8]
  output logic [sfe_pkg::OutDataW-1:0]     m_axis_tdata,
  // tx_valid[0], rx_valid[1], status[3:2]
  output logic [sfe_pkg::OutUserW-1:0]     m_axis_tuser,
  output logic                             m_axis_tlast
);
  import sfe_pkg::*;

  logic [ShiftW-1:0] read_shift_q;
  logic              accept;
  logic              push;
  logic              pop;
  logic              full;
  job_t              job;
  queue_head_t       head;

  // config register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_shift_q <= '0;
    end else if (cfg_valid_i) begin
      read_shift_q <= cfg_data_i;
    end
  end

  // input transfer whenever the queue has a free slot
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (s_axis_tuser),
    .opcode_i     (s_axis_tdata[1:0]),
    .address_i    (s_axis_tdata[33:2]),
    .word_count_i (s_axis_tdata[49:34]),
    .tx_word_i    (s_axis_tdata[81:50]),
    .rx_byte_i    (s_axis_tdata[89:82]),
    .read_shift_i (read_shift_q),
    .push_o       (push),
    .job_o        (job)
  );

  sfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  sfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> hdl/sfe_front.sv
// ----------------------------------------------------------------------------
// sfe_front
// accepts items, tracks the open frame, deskews received data, queues jobs
// ----------------------------------------------------------------------------
module sfe_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [1:0]                  cmd_i,
  input  logic [1:0]                  opcode_i,
  input  logic [31:0]                 address_i,
  input  logic [15:0]                 word_count_i,
  input  logic [31:0]                 tx_word_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic [sfe_pkg::ShiftW-1:0]  read_shift_i,
  output logic                        push_o,
  output sfe_pkg::job_t               job_o
);
  import sfe_pkg::*;

  logic              open_q, open_d;
  logic [1:0]        opc_q, opc_d;
  logic [15:0]       words_left_q, words_left_d;
  logic [IdxW-1:0]   len_q, len_d;
  logic [IdxW-1:0]   rx_idx_q, rx_idx_d;
  logic [23:0]       window_q, window_d;
  logic [31:0]       acc_q, acc_d;

  logic [23:0]       win_n;
  logic [IdxW-1:0]   rx_idx_inc;
  logic [7:0]        deskew_b;
  logic [31:0]       acc_b;
  logic [7:0]        x0, x1, x2, x3;
  logic [31:0]       wr_word;

  always_comb begin
    win_n      = {window_q[15:0], rx_byte_i};
    rx_idx_inc = rx_idx_q + IdxW'(1);
    deskew_b   = 8'(win_n >> (5'd16 - {1'b0, read_shift_i}));
    acc_b      = {acc_q[23:0], deskew_b};
    // final data byte, filled from the pad slot byte
    x0 = read_shift_i[3] ? win_n[7:0] : win_n[15:8];
    x1 = read_shift_i[2] ? {x0[3:0], win_n[7:4]} : x0;
    x2 = read_shift_i[1] ? {x1[5:0], win_n[7:6]} : x1;
    x3 = read_shift_i[0] ? {x2[6:0], win_n[7]}   : x2;
    wr_word = opc_q[OpcWriteBit] ? tx_word_i : 32'd0;
  end

  always_comb begin
    open_d       = open_q;
    opc_d        = opc_q;
    words_left_d = words_left_q;
    len_d        = len_q;
    rx_idx_d     = rx_idx_q;
    window_d     = window_q;
    acc_d        = acc_q;
    push_o       = 1'b0;
    job_o        = '{kind: JOB_ERROR, data: '0, pad: 1'b0, status: STATUS_STRAY};
    if (accept_i) begin
      push_o = 1'b1;
      case (cmd_i)
        CMD_START: begin
          if (word_count_i == 16'd0) begin
            job_o.status = STATUS_ZERO_COUNT;
          end else begin
            open_d       = 1'b1;
            opc_d        = opcode_i;
            words_left_d = word_count_i;
            len_d        = {1'b0, word_count_i, 2'b00} + IdxW'(FrameOverhead);
            rx_idx_d     = '0;
            window_d     = '0;
            acc_d        = '0;
            job_o.kind   = JOB_HEADER;
            job_o.status = STATUS_OK;
            job_o.data   = {6'd0, opcode_i, address_i, word_count_i};
          end
        end
        CMD_WORD: begin
          if (open_q && words_left_q != 16'd0) begin
            words_left_d = words_left_q - 16'd1;
            job_o.kind   = JOB_WORD;
            job_o.status = STATUS_OK;
            job_o.data   = {wr_word, 24'd0};
            job_o.pad    = (words_left_q == 16'd1);
            if (words_left_q == 16'd1 && rx_idx_q >= len_q) begin
              open_d = 1'b0;
            end
          end
        end
        CMD_RX_BYTE: begin
          if (open_q && rx_idx_q < len_q) begin
            push_o       = 1'b0;
            window_d     = win_n;
            rx_idx_d     = rx_idx_inc;
            job_o.kind   = JOB_RX_WORD;
            job_o.status = STATUS_OK;
            if (!opc_q[OpcWriteBit] && rx_idx_q >= IdxW'(FirstDataRx)) begin
              acc_d = acc_b;
              // a word completes every fourth data byte
              if (rx_idx_q[1:0] == 2'b00) begin
                push_o     = 1'b1;
                job_o.data = {24'd0, acc_b};
              end
              if (rx_idx_inc == len_q) begin
                acc_d      = {acc_b[23:0], x3};
                push_o     = 1'b1;
                job_o.data = {24'd0, acc_b[23:0], x3};
              end
            end
            if (words_left_q == 16'd0 && rx_idx_inc >= len_q) begin
              open_d = 1'b0;
            end
          end
        end
        default: begin
          job_o.status = STATUS_STRAY;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q       <= 1'b0;
      opc_q        <= '0;
      words_left_q <= '0;
      len_q        <= '0;
      rx_idx_q     <= '0;
      window_q     <= '0;
      acc_q        <= '0;
    end else begin
      open_q       <= open_d;
      opc_q        <= opc_d;
      words_left_q <= words_left_d;
      len_q        <= len_d;
      rx_idx_q     <= rx_idx_d;
      window_q     <= window_d;
      acc_q        <= acc_d;
    end
  end

endmodule

>>> hdl/sfe_queue.sv
// ----------------------------------------------------------------------------
// sfe_queue
// short job queue between front and back end
// ----------------------------------------------------------------------------
module sfe_queue #(
  parameter int unsigned DEPTH = sfe_pkg::QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sfe_pkg::job_t        job_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output sfe_pkg::queue_head_t head_o
);
  import sfe_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign full_o           = (count_q == CntW'(DEPTH));
  assign head_o.not_empty = (count_q != '0);
  assign head_o.head      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> hdl/sfe_back.sv
// ----------------------------------------------------------------------------
// sfe_back
// expands queued jobs into result transfers through an output register
// ----------------------------------------------------------------------------
module sfe_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sfe_pkg::queue_head_t              head_i,
  output logic                              pop_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sfe_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic [sfe_pkg::OutUserW-1:0]      m_axis_tuser,
  output logic                              m_axis_tlast
);
  import sfe_pkg::*;

  logic [2:0]              idx_q, idx_d;
  logic                    valid_q, valid_d;
  logic [OutDataW-1:0]     data_q;
  logic [OutUserW-1:0]     user_q;
  logic                    last_q;

  logic                    emit;
  logic                    is_last;
  logic [2:0]              last_idx;
  logic [JobDataW-1:0]     shifted;
  logic                    tx_v, rx_v;
  logic [7:0]              tx_byte;
  logic [31:0]             rx_w;
  status_e                 st;

  always_comb begin
    case (head_i.head.kind)
      JOB_HEADER: last_idx = 3'(HdrLastIdx);
      JOB_WORD:   last_idx = head_i.head.pad ? 3'(PadLastIdx) : 3'(WordLastIdx);
      default:    last_idx = 3'd0;
    endcase
    is_last = (idx_q == last_idx);
    emit    = head_i.not_empty && (!valid_q || m_axis_tready);
    pop_o   = emit && is_last;
    shifted = head_i.head.data << {idx_q, 3'b000};
    tx_v    = (head_i.head.kind == JOB_HEADER) || (head_i.head.kind == JOB_WORD);
    rx_v    = (head_i.head.kind == JOB_RX_WORD);
    tx_byte = tx_v ? shifted[JobDataW-1 -: 8] : 8'd0;
    rx_w    = rx_v ? head_i.head.data[31:0] : 32'd0;
    st      = (head_i.head.kind == JOB_ERROR) ? head_i.head.status : STATUS_OK;

    idx_d   = idx_q;
    valid_d = valid_q;
    if (m_axis_tready) begin
      valid_d = 1'b0;
    end
    if (emit) begin
      valid_d = 1'b1;
      idx_d   = is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      data_q <= {rx_w, tx_byte};
      user_q <= {st, rx_v, tx_v};
      last_q <= is_last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tlast  = last_q;

endmodule

>>> hdl/sfe_checker.sv
// ----------------------------------------------------------------------------
// sfe_checker
// port level checks of the frame engine result stream
// ----------------------------------------------------------------------------
module sfe_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [sfe_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic [sfe_pkg::OutUserW-1:0] m_axis_tuser,
  input  logic                         m_axis_tlast
);
  import sfe_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // byte and word results never share a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("tx and rx flags both set");

  // an error result is alone, empty and closes its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3:2] != 2'(STATUS_OK) |->
      m_axis_tlast && m_axis_tuser[1:0] == 2'b00 && m_axis_tdata == '0)
    else $error("malformed error result");

  // a read word is always the single result of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
    else $error("read word result malformed");

endmodule

bind spi_register_frame_engine sfe_checker u_sfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
